[rtl/core/ipcfe_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ipcfe_pkg
// Shared types and constants of the address cache with FIFO replacement
// and age-based expiry.
// ----------------------------------------------------------------------------
package ipcfe_pkg;

    localparam int BLOCKS   = 256;
    localparam int WAYS     = 16;
    localparam int BLK_W    = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
    localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int FILL_W   = $clog2(WAYS + 1);
    localparam int ENT_W    = 32 + 16 + 32;
    localparam int ROW_W    = WAYS * ENT_W;
    localparam int META_W   = WAYS + FILL_W + WAY_W;

    localparam logic [1:0] REG_PORT_CMP = 2'd0;
    localparam logic [1:0] REG_STALE    = 2'd1;

    localparam logic [15:0] STALE_RESET = 16'd1800;

    typedef enum logic [1:0] {
        FN_LOOKUP = 2'd0,
        FN_TOUCH  = 2'd1,
        FN_ADD    = 2'd2,
        FN_DELETE = 2'd3
    } t_func;

    typedef enum logic {
        BS_IDLE = 1'b0,
        BS_EVAL = 1'b1
    } t_bstate;

    typedef struct packed {
        t_func       func;
        logic [31:0] addr;
        logic [15:0] port;
        logic [31:0] now;
    } t_job;

    typedef struct packed {
        logic        port_cmp;
        logic [15:0] stale;
    } t_cfg;

endpackage
`default_nettype wire

[rtl/core/ipcfe_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ipcfe_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module ipcfe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

[rtl/core/ipcfe_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ipcfe_front
// Request intake: decodes the request kind and holds up to two pending
// transactions for the cache engine.
// ----------------------------------------------------------------------------
module ipcfe_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire logic [1:0]      i_func,
    input  wire logic [31:0]     i_ip_addr,
    input  wire logic [15:0]     i_port_num,
    input  wire logic [31:0]     i_now_seconds,
    output logic                 o_job_valid,
    output ipcfe_pkg::t_job      o_job,
    input  wire logic            i_job_pop
);
    import ipcfe_pkg::*;

    t_job       r_q [2];
    logic       r_wptr, r_rptr;
    logic [1:0] r_cnt;
    logic       push;
    t_job       job_in;

    assign o_ready     = (r_cnt != 2'd2);
    assign push        = i_valid && o_ready;
    assign o_job_valid = (r_cnt != 2'd0);
    assign o_job       = r_q[r_rptr];

    always_comb begin
        job_in.func = t_func'(i_func);
        job_in.addr = i_ip_addr;
        job_in.port = i_port_num;
        job_in.now  = i_now_seconds;
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wptr] <= job_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_job_pop) begin
                r_rptr <= ~r_rptr;
            end
            case ({push, i_job_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end
endmodule
`default_nettype wire

[rtl/core/ipcfe_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ipcfe_back
// Cache engine: reads a whole block, compares all ways, writes back the
// parts of the block that change and registers the result.
// ----------------------------------------------------------------------------
module ipcfe_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  ipcfe_pkg::t_cfg      i_cfg,
    input  wire logic            i_job_valid,
    input  ipcfe_pkg::t_job      i_job,
    output logic                 o_job_pop,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output logic                 o_hit,
    output logic [31:0]          o_entry_time,
    output logic                 o_changed
);
    import ipcfe_pkg::*;

    t_bstate           r_state, n_state;
    t_job              r_job;
    logic [BLOCKS-1:0] r_row_ok;
    logic              r_out_valid;
    logic              r_hit, r_changed;
    logic [31:0]       r_time;

    logic [BLK_W-1:0]  blk, rd_blk;
    logic [ROW_W-1:0]  data_row, data_wrow;
    logic [META_W-1:0] meta_raw, meta_wrow;
    logic              data_we, meta_we, do_eval, out_free;

    logic [WAYS-1:0]   valid_v, match, n_valid;
    logic [FILL_W-1:0] fill, n_fill;
    logic [WAY_W-1:0]  next, n_next, sel_way, add_way;
    logic              found, expired, res_hit, res_changed;
    logic [31:0]       res_time, sel_stamp;
    logic [32:0]       limit;

    assign blk    = r_job.addr[BLK_W-1:0];
    assign rd_blk = o_job_pop ? i_job.addr[BLK_W-1:0] : blk;

    ipcfe_ram #(.WIDTH(ROW_W), .DEPTH(BLOCKS)) u_data (
        .i_clk  (i_clk),
        .i_we   (data_we),
        .i_waddr(blk),
        .i_wdata(data_wrow),
        .i_raddr(rd_blk),
        .o_rdata(data_row)
    );

    ipcfe_ram #(.WIDTH(META_W), .DEPTH(BLOCKS)) u_meta (
        .i_clk  (i_clk),
        .i_we   (meta_we),
        .i_waddr(blk),
        .i_wdata(meta_wrow),
        .i_raddr(rd_blk),
        .o_rdata(meta_raw)
    );

    assign out_free = !r_out_valid || i_ready;
    assign do_eval  = (r_state == BS_EVAL) && out_free;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BS_IDLE: if (i_job_valid) n_state = BS_EVAL;
            BS_EVAL: if (out_free)    n_state = BS_IDLE;
            default: n_state = BS_IDLE;
        endcase
    end

    always_comb begin
        o_job_pop = (r_state == BS_IDLE) && i_job_valid;
    end

    // A block whose metadata was never written reads as empty.
    always_comb begin
        if (r_row_ok[blk]) begin
            {valid_v, fill, next} = meta_raw;
        end else begin
            {valid_v, fill, next} = '0;
        end
    end

    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            match[w] = valid_v[w]
                && (data_row[w*ENT_W+48 +: 32] == r_job.addr)
                && (!i_cfg.port_cmp || data_row[w*ENT_W+32 +: 16] == r_job.port);
        end
    end

    // Search the filled ways from newest to oldest; the first match wins.
    always_comb begin
        int way;
        found   = 1'b0;
        sel_way = '0;
        for (int k = WAYS - 1; k >= 0; k--) begin
            way = (int'(next) + 2 * WAYS - 1 - k) % WAYS;
            if (k < int'(fill) && match[way]) begin
                found   = 1'b1;
                sel_way = WAY_W'(way);
            end
        end
    end

    assign sel_stamp = data_row[int'(sel_way)*ENT_W +: 32];
    assign limit     = {1'b0, sel_stamp} + {17'd0, i_cfg.stale};
    assign expired   = found && (i_cfg.stale != 16'd0)
                       && (limit < {1'b0, r_job.now});
    assign add_way   = (int'(fill) < WAYS) ? WAY_W'(fill) : next;

    always_comb begin
        res_hit     = 1'b0;
        res_time    = 32'd0;
        res_changed = 1'b0;
        n_valid     = valid_v;
        n_fill      = fill;
        n_next      = next;
        data_wrow   = data_row;
        data_we     = 1'b0;
        meta_we     = 1'b0;
        if (r_job.func == FN_ADD) begin
            data_wrow[int'(add_way)*ENT_W +: ENT_W] = {r_job.addr, r_job.port, r_job.now};
            n_valid[add_way] = 1'b1;
            n_next  = (int'(next) == WAYS - 1) ? '0 : next + WAY_W'(1);
            if (int'(fill) < WAYS) begin
                n_fill = fill + FILL_W'(1);
            end
            res_changed = 1'b1;
            data_we     = do_eval;
            meta_we     = do_eval;
        end else if (expired) begin
            n_valid[sel_way] = 1'b0;
            res_changed      = 1'b1;
            meta_we          = do_eval;
        end else if (found) begin
            res_hit  = 1'b1;
            res_time = sel_stamp;
            if (r_job.func == FN_TOUCH) begin
                data_wrow[int'(sel_way)*ENT_W +: 32] = r_job.now;
                data_we = do_eval;
            end else if (r_job.func == FN_DELETE) begin
                n_valid[sel_way] = 1'b0;
                res_changed      = 1'b1;
                meta_we          = do_eval;
            end
        end
        meta_wrow = {n_valid, n_fill, n_next};
    end

    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_job <= i_job;
        end
        if (do_eval) begin
            r_hit     <= res_hit;
            r_time    <= res_time;
            r_changed <= res_changed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BS_IDLE;
            r_row_ok    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (meta_we) begin
                r_row_ok[blk] <= 1'b1;
            end
            if (do_eval) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid      = r_out_valid;
    assign o_hit        = r_hit;
    assign o_entry_time = r_time;
    assign o_changed    = r_changed;

    a_write_in_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (data_we || meta_we) |-> (r_state == BS_EVAL))
        else $error("cache write outside evaluation");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        meta_we |-> (int'(n_fill) <= WAYS))
        else $error("block fill exceeds way count");

    a_result_from_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == BS_EVAL))
        else $error("result without evaluation");

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_pop |=> (r_state == BS_EVAL))
        else $error("popped transaction not evaluated");
endmodule
`default_nettype wire

[rtl/core/ip_address_cache_fifo_expiry_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ip_address_cache_fifo_expiry_top
// Set-associative IPv4 address cache with FIFO replacement and expiry.
// ----------------------------------------------------------------------------
// Requests (lookup, touch, add, delete) enter on a valid/ready channel with
// an address, a port and the current time; each produces exactly one result
// (hit, entry time, changed) on a valid/ready output channel.
// A two-entry queue decouples intake from the cache engine. The engine reads
// a whole block (all ways plus metadata) from RAM, then compares every way,
// writes back what changed and registers the result once the output is free.
// The engine takes a new transaction only after the last one is done, since
// each block is read from the block RAMs and then written back.
// When the receiver stalls the result register holds, the engine waits, and
// the queue fills before o_ready drops.
// Reset empties the queue and marks every block empty through one flag per
// block, so no clearing pass is needed; registers return to port compare on
// and a stale time of 1800 seconds. Configuration is to be written through
// the APB port only while no transaction is in flight (not enforced).
// ----------------------------------------------------------------------------
module ip_address_cache_fifo_expiry_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_func,
    input  wire logic [31:0] i_ip_addr,
    input  wire logic [15:0] i_port_num,
    input  wire logic [31:0] i_now_seconds,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic             o_hit,
    output logic [31:0]      o_entry_time,
    output logic             o_changed,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import ipcfe_pkg::*;

    t_cfg       r_cfg;
    t_job       job;
    logic       job_valid, job_pop, wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = {1'b0, paddr[2]};
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.port_cmp <= 1'b1;
            r_cfg.stale    <= STALE_RESET;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_PORT_CMP: r_cfg.port_cmp <= pwdata[0];
                REG_STALE:    r_cfg.stale    <= pwdata[15:0];
                default:      r_cfg          <= r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_PORT_CMP: prdata = {31'd0, r_cfg.port_cmp};
            REG_STALE:    prdata = {16'd0, r_cfg.stale};
            default:      prdata = 32'd0;
        endcase
    end

    ipcfe_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_func       (i_func),
        .i_ip_addr    (i_ip_addr),
        .i_port_num   (i_port_num),
        .i_now_seconds(i_now_seconds),
        .o_job_valid  (job_valid),
        .o_job        (job),
        .i_job_pop    (job_pop)
    );

    ipcfe_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job_valid (job_valid),
        .i_job       (job),
        .o_job_pop   (job_pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_hit       (o_hit),
        .o_entry_time(o_entry_time),
        .o_changed   (o_changed)
    );
endmodule
`default_nettype wire
